[rtl/assert_macros.svh]
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

[rtl/tchv_pkg.sv]
`default_nettype none
package tchv_pkg;

  localparam int PosW = 6;

  localparam logic [PosW-1:0] HDR_LEN        = 6'd55;
  localparam logic [PosW-1:0] POS_SAT        = 6'd63;
  localparam logic [PosW-1:0] HYPHEN_A       = 6'd2;
  localparam logic [PosW-1:0] HYPHEN_B       = 6'd35;
  localparam logic [PosW-1:0] HYPHEN_C       = 6'd52;
  localparam logic [PosW-1:0] TRACE_LO_FIRST = 6'd19;

  localparam logic [7:0] CH_HYPHEN = 8'h2d;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_F   = 8'h66;
  localparam logic [7:0] HEX_A_OFS = 8'd87;  // 'a' - 10
  localparam logic [7:0] VER_BAD   = 8'hff;

  // Which field a byte position feeds
  localparam logic [2:0] FLD_NONE   = 3'd0;
  localparam logic [2:0] FLD_VER    = 3'd1;
  localparam logic [2:0] FLD_TUP    = 3'd2;
  localparam logic [2:0] FLD_TLO    = 3'd3;
  localparam logic [2:0] FLD_PARENT = 3'd4;
  localparam logic [2:0] FLD_FLAGS  = 3'd5;

  typedef struct packed {
    logic       bad;
    logic [2:0] field;
    logic [3:0] nib;
    logic       nonzero;
  } dec_t;

endpackage
`default_nettype wire

[rtl/tchv_byte_decode.sv]
`default_nettype none
module tchv_byte_decode (
  input  logic [tchv_pkg::PosW-1:0] pos_i,
  input  logic [7:0]                byte_i,
  output tchv_pkg::dec_t            dec_o
);
  import tchv_pkg::*;

  logic       is_dig;
  logic       is_af;
  logic [7:0] dig_val;
  logic [7:0] af_val;
  logic [3:0] nib;

  assign is_dig  = (byte_i >= CH_ZERO) && (byte_i <= CH_NINE);
  assign is_af   = (byte_i >= CH_LO_A) && (byte_i <= CH_LO_F);
  assign dig_val = byte_i - CH_ZERO;
  assign af_val  = byte_i - HEX_A_OFS;
  // non-hex digits shift in as zero
  assign nib = is_dig ? dig_val[3:0] : (is_af ? af_val[3:0] : 4'd0);

  always_comb begin
    dec_o.nib     = nib;
    dec_o.nonzero = 1'b0;
    dec_o.field   = FLD_NONE;
    dec_o.bad     = 1'b0;
    priority if (pos_i >= HDR_LEN) begin
      dec_o.bad = 1'b1;
    end else if (pos_i == HYPHEN_A || pos_i == HYPHEN_B || pos_i == HYPHEN_C) begin
      dec_o.bad = (byte_i != CH_HYPHEN);
    end else begin
      dec_o.bad     = !(is_dig || is_af);
      dec_o.nonzero = (byte_i != CH_ZERO);
      priority if (pos_i < HYPHEN_A) begin
        dec_o.field = FLD_VER;
      end else if (pos_i < TRACE_LO_FIRST) begin
        dec_o.field = FLD_TUP;
      end else if (pos_i < HYPHEN_B) begin
        dec_o.field = FLD_TLO;
      end else if (pos_i < HYPHEN_C) begin
        dec_o.field = FLD_PARENT;
      end else begin
        dec_o.field = FLD_FLAGS;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/trace_context_header_validator.sv]
// A result appears on out_* in the cycle after its last byte is accepted.
// Throughput: one header byte per cycle while in_ready is high; the byte decode
// and field shift sit between the field registers and the result register.
// Any byte waits while an untaken result sits in the result register.
// Reset (rst_n low, synchronous): fields cleared, result register empty, tracing enabled.
`default_nettype none
module trace_context_header_validator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_value_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_accepted,
  output logic [7:0]  out_version_code,
  output logic [63:0] out_trace_id_upper,
  output logic [63:0] out_trace_id_lower,
  output logic [63:0] out_parent_span_id,
  output logic [7:0]  out_flag_bits,
  input  logic        cfg_write_en,
  input  logic        cfg_write_data
);
  import tchv_pkg::*;

  logic            enable_r;
  logic [PosW-1:0] pos_r, pos_nxt;
  logic            bad_r, bad_nxt;
  logic            tnz_r, tnz_nxt;
  logic            pnz_r, pnz_nxt;
  logic [7:0]      ver_r, ver_nxt;
  logic [63:0]     tup_r, tup_nxt;
  logic [63:0]     tlo_r, tlo_nxt;
  logic [63:0]     par_r, par_nxt;
  logic [7:0]      flg_r, flg_nxt;

  logic            out_valid_r;
  logic            acc_r;
  logic [7:0]      o_ver_r;
  logic [63:0]     o_tup_r, o_tlo_r, o_par_r;
  logic [7:0]      o_flg_r;

  dec_t            dec;
  logic            in_fire;
  logic            take;
  logic            load_out;
  logic            ok;

  tchv_byte_decode u_dec (
    .pos_i  (pos_r),
    .byte_i (in_value_byte),
    .dec_o  (dec)
  );

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign take     = in_fire && enable_r;
  assign load_out = take && in_last_byte;

  always_comb begin
    pos_nxt = (pos_r == POS_SAT) ? pos_r : pos_r + 6'd1;
    bad_nxt = bad_r | dec.bad;
    tnz_nxt = tnz_r;
    pnz_nxt = pnz_r;
    ver_nxt = ver_r;
    tup_nxt = tup_r;
    tlo_nxt = tlo_r;
    par_nxt = par_r;
    flg_nxt = flg_r;
    unique case (dec.field)
      FLD_VER:    ver_nxt = {ver_r[3:0], dec.nib};
      FLD_TUP: begin
        tup_nxt = {tup_r[59:0], dec.nib};
        tnz_nxt = tnz_r | dec.nonzero;
      end
      FLD_TLO: begin
        tlo_nxt = {tlo_r[59:0], dec.nib};
        tnz_nxt = tnz_r | dec.nonzero;
      end
      FLD_PARENT: begin
        par_nxt = {par_r[59:0], dec.nib};
        pnz_nxt = pnz_r | dec.nonzero;
      end
      FLD_FLAGS:  flg_nxt = {flg_r[3:0], dec.nib};
      default: ;
    endcase
    ok = (pos_nxt == HDR_LEN) && !bad_nxt && (ver_nxt != VER_BAD) && tnz_nxt && pnz_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b1;
    end else if (cfg_write_en) begin
      enable_r <= cfg_write_data;
    end
  end

  // Header state; a last byte returns it to zero even with tracing off
  always_ff @(posedge clk) begin
    if (!rst_n || (in_fire && in_last_byte)) begin
      pos_r <= '0;
      bad_r <= 1'b0;
      tnz_r <= 1'b0;
      pnz_r <= 1'b0;
      ver_r <= '0;
      tup_r <= '0;
      tlo_r <= '0;
      par_r <= '0;
      flg_r <= '0;
    end else if (take) begin
      pos_r <= pos_nxt;
      bad_r <= bad_nxt;
      tnz_r <= tnz_nxt;
      pnz_r <= pnz_nxt;
      ver_r <= ver_nxt;
      tup_r <= tup_nxt;
      tlo_r <= tlo_nxt;
      par_r <= par_nxt;
      flg_r <= flg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // rejected headers report all-zero fields
  always_ff @(posedge clk) begin
    if (load_out) begin
      acc_r   <= ok;
      o_ver_r <= ok ? ver_nxt : 8'd0;
      o_tup_r <= ok ? tup_nxt : 64'd0;
      o_tlo_r <= ok ? tlo_nxt : 64'd0;
      o_par_r <= ok ? par_nxt : 64'd0;
      o_flg_r <= ok ? flg_nxt : 8'd0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_accepted       = acc_r;
  assign out_version_code   = o_ver_r;
  assign out_trace_id_upper = o_tup_r;
  assign out_trace_id_lower = o_tlo_r;
  assign out_parent_span_id = o_par_r;
  assign out_flag_bits      = o_flg_r;

endmodule
`default_nettype wire

[rtl/tchv_checker.sv]
`default_nettype none
`include "assert_macros.svh"
module tchv_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_accepted,
  input logic [7:0]  out_version_code,
  input logic [63:0] out_trace_id_upper,
  input logic [63:0] out_trace_id_lower,
  input logic [63:0] out_parent_span_id,
  input logic [7:0]  out_flag_bits
);
  import tchv_pkg::*;

  logic fields_zero;
  logic ids_sane;

  assign fields_zero = (out_version_code == 8'd0) && (out_trace_id_upper == 64'd0) &&
                       (out_trace_id_lower == 64'd0) && (out_parent_span_id == 64'd0) &&
                       (out_flag_bits == 8'd0);
  assign ids_sane    = (out_version_code != VER_BAD) &&
                       ((out_trace_id_upper != 64'd0) || (out_trace_id_lower != 64'd0)) &&
                       (out_parent_span_id != 64'd0);

  `ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_valid)
  `ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid)
  `ASSERT_CLK(a_ready_rule, in_ready == (!out_valid || out_ready))
  `ASSERT_CLK(a_reject_zero, out_valid && !out_accepted |-> fields_zero)
  `ASSERT_CLK(a_accept_sane, out_valid && out_accepted |-> ids_sane)

endmodule

bind trace_context_header_validator tchv_checker u_tchv_checker (.*);
`default_nettype wire
